@@ hdl/adcm_pkg.sv @@
// Shared types and constants for the ADC channel scan level monitor.
`timescale 1ns / 1ps
`default_nettype none

package adcm_pkg;

   localparam int NUM_CHANNELS = 5;
   localparam int CHAN_W       = 3;
   localparam int VALUE_W      = 12;
   localparam int LIMIT_W      = 8;
   localparam int COUNT_W      = 9;
   localparam int ZONE_W       = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 12;

   localparam logic [CHAN_W-1:0] POWER_CHANNEL = 3'd4;
   localparam logic [CHAN_W-1:0] ZONE_CHANNEL  = 3'd0;

   // zone codes
   localparam logic [ZONE_W-1:0] ZONE_NO_PULSE = 3'd0;
   localparam logic [ZONE_W-1:0] ZONE_TOO_BIG  = 3'd1;
   localparam logic [ZONE_W-1:0] ZONE_UPPER    = 3'd2;
   localparam logic [ZONE_W-1:0] ZONE_NORMAL   = 3'd3;
   localparam logic [ZONE_W-1:0] ZONE_LOWER    = 3'd4;
   localparam logic [ZONE_W-1:0] ZONE_TOO_LOW  = 3'd5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_ALARM = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_TOL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_TOL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_ALARM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_MIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIMIT   = 3'd5;

   typedef struct packed {
      logic [VALUE_W-1:0] upper_alarm_level;
      logic [VALUE_W-1:0] upper_tolerance_level;
      logic [VALUE_W-1:0] lower_tolerance_level;
      logic [VALUE_W-1:0] lower_alarm_level;
      logic [VALUE_W-1:0] power_minimum;
      logic [LIMIT_W-1:0] low_count_limit;
   } cfg_type;

   typedef struct packed {
      logic              pulse_active;
      logic [3:0]        raw_high;
      logic [7:0]        raw_low;
   } sample_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  sample_channel;
      logic [VALUE_W-1:0] sample_value;
      logic [ZONE_W-1:0]  input_zone;
      logic               zone_changed;
      logic               power_fault;
      logic               output_ok;
      logic [CHAN_W-1:0]  next_channel;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/adcm_if.sv @@
// Valid/ready channel interfaces for reading and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface adcm_req_if;
   logic       valid;
   logic       ready;
   logic       pulse_active;
   logic [3:0] raw_high;
   logic [7:0] raw_low;

   modport source (output valid, pulse_active, raw_high, raw_low, input ready);
   modport sink   (input valid, pulse_active, raw_high, raw_low, output ready);
endinterface

interface adcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  sample_channel;
   logic [11:0] sample_value;
   logic [2:0]  input_zone;
   logic        zone_changed;
   logic        power_fault;
   logic        output_ok;
   logic [2:0]  next_channel;

   modport source (output valid, sample_channel, sample_value, input_zone, zone_changed,
                   power_fault, output_ok, next_channel, input ready);
   modport sink   (input valid, sample_channel, sample_value, input_zone, zone_changed,
                   power_fault, output_ok, next_channel, output ready);
endinterface

`default_nettype wire

@@ hdl/adcm_cfg_regs.sv @@
// Threshold and limit registers behind the write-only config port.
`timescale 1ns / 1ps
`default_nettype none

module adcm_cfg_regs
   import adcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   write_enable,
   input  wire logic [CSR_INDEX_W-1:0] write_index,
   input  wire logic [CSR_DATA_W-1:0]  write_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         unique case (write_index)
            CSR_UPPER_ALARM: cfg_in.upper_alarm_level     = write_data;
            CSR_UPPER_TOL:   cfg_in.upper_tolerance_level = write_data;
            CSR_LOWER_TOL:   cfg_in.lower_tolerance_level = write_data;
            CSR_LOWER_ALARM: cfg_in.lower_alarm_level     = write_data;
            CSR_POWER_MIN:   cfg_in.power_minimum         = write_data;
            CSR_LOW_LIMIT:   cfg_in.low_count_limit       = write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_alarm_level     <= 12'd4095;
         cfg_ff.upper_tolerance_level <= 12'd3072;
         cfg_ff.lower_tolerance_level <= 12'd1024;
         cfg_ff.lower_alarm_level     <= 12'd0;
         cfg_ff.power_minimum         <= 12'd0;
         cfg_ff.low_count_limit       <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hdl/adcm_monitor.sv @@
// Sample conversion, zone classification, power fault tracking and channel scan state.
`timescale 1ns / 1ps
`default_nettype none

module adcm_monitor
   import adcm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,      // a pulse beat leaves the input register
   input  sample_type sample,
   input  cfg_type    cfg,
   output result_type result
);

   logic [CHAN_W-1:0]  chan_ff, chan_in;
   logic [ZONE_W-1:0]  zone_ff, zone_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               fault_ff, fault_in;
   logic               good_ff, good_in;

   logic [VALUE_W-1:0] value;
   logic [ZONE_W-1:0]  zone_class;
   logic [COUNT_W-1:0] count_inc;
   logic [CHAN_W:0]    chan_sum;
   logic               changed;

   // the offset of 2048 only inverts the top bit of the 12-bit two's complement reading
   assign value = {~sample.raw_high[3], sample.raw_high[2:0], sample.raw_low};

   always_comb begin
      if (value >= cfg.upper_alarm_level)          zone_class = ZONE_TOO_BIG;
      else if (value >= cfg.upper_tolerance_level) zone_class = ZONE_UPPER;
      else if (value >= cfg.lower_tolerance_level) zone_class = ZONE_NORMAL;
      else if (value >= cfg.lower_alarm_level)     zone_class = ZONE_LOWER;
      else                                         zone_class = ZONE_TOO_LOW;
   end

   assign count_inc = count_ff + COUNT_W'(1);
   assign chan_sum  = {1'b0, chan_ff} + (CHAN_W+1)'(1);

   always_comb begin
      zone_in  = zone_ff;
      count_in = count_ff;
      fault_in = fault_ff;
      good_in  = good_ff;
      changed  = 1'b0;
      if (chan_ff == ZONE_CHANNEL && zone_class != zone_ff) begin
         zone_in = zone_class;
         changed = 1'b1;
      end
      if (chan_ff == POWER_CHANNEL) begin
         if (value < cfg.power_minimum) begin
            if (count_inc > {1'b0, cfg.low_count_limit}) begin
               fault_in = 1'b1;
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end else begin
            good_in  = 1'b1;
            fault_in = 1'b0;
            count_in = '0;
         end
      end
      if (chan_sum >= (CHAN_W+1)'(NUM_CHANNELS)) chan_in = '0;
      else                                        chan_in = chan_sum[CHAN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         zone_ff  <= ZONE_NO_PULSE;
         count_ff <= '0;
         fault_ff <= 1'b0;
         good_ff  <= 1'b0;
      end else if (advance) begin
         chan_ff  <= chan_in;
         zone_ff  <= zone_in;
         count_ff <= count_in;
         fault_ff <= fault_in;
         good_ff  <= good_in;
      end
   end

   always_comb begin
      result.sample_channel = chan_ff;
      result.sample_value   = value;
      result.input_zone     = zone_in;
      result.zone_changed   = changed;
      result.power_fault    = fault_in;
      result.output_ok      = good_in;
      result.next_channel   = chan_in;
   end

endmodule

`default_nettype wire

@@ hdl/adc_channel_scan_level_monitor.sv @@
// Top level: input register, monitor logic, result register and config port.
// A reading accepted into the input register moves into the result register once that is free, then its beat is valid.
// Throughput: one reading per cycle while results are taken; the input register and result register each
// hold one beat, so one new reading can be taken while a finished result waits.
// Readings without a pulse are consumed with no result beat.
// Synchronous active-high reset restores default thresholds, channel 0, zone 0 and clears flags.
`timescale 1ns / 1ps
`default_nettype none

module adc_channel_scan_level_monitor
   import adcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   adcm_req_if.sink                    req_chan,
   adcm_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff;
   sample_type in_beat_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_beat_ff;

   logic out_free;
   logic in_leave;
   logic advance;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   // non-pulse beats leave without needing the result register
   assign in_leave = in_valid_ff && (!in_beat_ff.pulse_active || out_free);
   assign advance  = in_leave && in_beat_ff.pulse_active;
   assign req_chan.ready = !in_valid_ff || in_leave;

   adcm_cfg_regs u_cfg (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .write_index  (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   adcm_monitor u_mon (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_beat_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_beat_ff.pulse_active <= req_chan.pulse_active;
         in_beat_ff.raw_high     <= req_chan.raw_high;
         in_beat_ff.raw_low      <= req_chan.raw_low;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance)                   out_valid_in = 1'b1;
      else if (rsp_chan.ready)       out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_beat_ff <= result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.sample_channel = out_beat_ff.sample_channel;
   assign rsp_chan.sample_value   = out_beat_ff.sample_value;
   assign rsp_chan.input_zone     = out_beat_ff.input_zone;
   assign rsp_chan.zone_changed   = out_beat_ff.zone_changed;
   assign rsp_chan.power_fault    = out_beat_ff.power_fault;
   assign rsp_chan.output_ok      = out_beat_ff.output_ok;
   assign rsp_chan.next_channel   = out_beat_ff.next_channel;

endmodule

`default_nettype wire
